FILE: sv/sacl_pkg.sv
// Shared types and register indexes for the set-associative cache lookup block.
package sacl_pkg;

    localparam int CFG_W = 4;

    typedef enum logic [2:0] {
        REG_INDEX_BITS  = 3'd0,
        REG_OFFSET_BITS = 3'd1,
        REG_WAYS_USED   = 3'd2,
        REG_POLICY      = 3'd3,
        REG_PREFETCH    = 3'd4
    } t_reg_idx;

    localparam logic OP_WRITE   = 1'b1;
    localparam logic POLICY_LRU = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLEAR = 7'b0000010,
        ST_ADDR  = 7'b0000100,
        ST_READ  = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_WRITE = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

endpackage

FILE: sv/set_assoc_cache_lookup_prefetch.sv
// Top level: tag-only set-associative cache with FIFO/LRU and next-line prefetch.
//
//  port group    dir  timing
//  start/data    in   taken when start and !busy
//  o_*           out  o_valid high one cycle per item
//  i_cfg_*       in   written when i_cfg_we
//
// An item walks the ways one at a time (tag and stamp read, then compare) through
// the shared compare and stamp minimum unit, then the set gets its write-back. A
// miss with prefetch takes two set walks.
// After reset a clearing pass clears the valid bits of every set before the
// first item; busy is high meanwhile. The receiver cannot stall; each result
// shows for one cycle.
module set_assoc_cache_lookup_prefetch #(
    parameter int SETS       = 256,
    parameter int WAYS       = 8,
    parameter int ADDR_BITS  = 48,
    parameter int STAMP_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [sacl_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_opcode,
    input  logic [ADDR_BITS-1:0]   i_address,
    output logic                   o_valid,
    output logic                   o_hit,
    output logic                   o_prefetch_filled,
    output logic [31:0]            o_hits_total,
    output logic [31:0]            o_misses_total,
    output logic [31:0]            o_reads_total,
    output logic [31:0]            o_writes_total
);
    import sacl_pkg::*;

    localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int DEPTH = SETS * WAYS;
    localparam int MW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(SETS + 1);
    localparam int WCW   = $clog2(WAYS + 1);

    // memories: per set a row of valid bits, tags and stamps per line
    logic [WAYS-1:0]       m_valid [SETS];
    logic [ADDR_BITS-1:0]  m_tag   [DEPTH];
    logic [STAMP_BITS-1:0] m_stamp [DEPTH];

    logic [3:0] r_index_bits, r_offset_bits, r_ways_used;
    logic       r_policy, r_prefetch;

    t_state r_state;
    logic [CW-1:0]        r_clr;
    logic [ADDR_BITS-1:0] r_addr;
    logic                 r_pf_phase;
    logic [SW-1:0]        r_set;
    logic [ADDR_BITS-1:0] r_tag;
    logic [WAYS-1:0]      r_vrow;
    logic [WCW-1:0]       r_way;
    logic [ADDR_BITS-1:0] r_rd_tag;
    logic [STAMP_BITS-1:0] r_rd_stamp;
    logic                 r_found, r_inv;
    logic [WW-1:0]        r_hit_way, r_vic_way;
    logic [STAMP_BITS-1:0] r_vic_stamp;
    logic [STAMP_BITS-1:0] r_stamp_ctr;
    logic [31:0]          r_hits, r_misses, r_reads, r_writes;
    logic                 r_hit, r_pf;

    logic [WCW-1:0]       w_nways;
    logic [ADDR_BITS-1:0] w_idx_bits, w_tagv;
    logic [SW-1:0]        w_set;
    logic [MW-1:0]        w_rd_addr, w_wr_addr;
    logic [WW-1:0]        w_cur;
    logic                 w_cur_valid;
    logic [WW-1:0]        w_fill_way;
    logic                 w_stamp_wr;

    always_comb begin
        if (r_ways_used == 4'd0) begin
            w_nways = WCW'(1);
        end else if (32'(r_ways_used) > WAYS) begin
            w_nways = WCW'(WAYS);
        end else begin
            w_nways = WCW'(r_ways_used);
        end
    end

    // set and tag of r_addr under current geometry
    always_comb begin
        w_idx_bits = (r_addr >> r_offset_bits) & ~({ADDR_BITS{1'b1}} << r_index_bits);
        w_set      = SW'(w_idx_bits % SETS);
        w_tagv     = r_addr >> (5'(r_offset_bits) + 5'(r_index_bits));
    end

    assign w_cur       = r_way[WW-1:0];
    assign w_cur_valid = r_vrow[w_cur];
    assign w_rd_addr   = MW'(32'(r_set) * WAYS + 32'(w_cur));
    assign w_fill_way  = r_found ? r_hit_way : r_vic_way;
    assign w_wr_addr   = MW'(32'(r_set) * WAYS + 32'(w_fill_way));
    // fills always stamp; a hit only under LRU and never in the prefetch lookup
    assign w_stamp_wr  = !r_found || (r_policy == POLICY_LRU && !r_pf_phase);
    assign busy        = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits  <= 4'd0;
            r_offset_bits <= 4'd6;
            r_ways_used   <= 4'd1;
            r_policy      <= 1'b0;
            r_prefetch    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_INDEX_BITS:  r_index_bits  <= i_cfg_data;
                REG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                REG_WAYS_USED:   r_ways_used   <= i_cfg_data;
                REG_POLICY:      r_policy      <= i_cfg_data[0];
                REG_PREFETCH:    r_prefetch    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            m_valid[r_clr[SW-1:0]] <= '0;
        end else if (r_state == ST_ADDR) begin
            r_vrow <= m_valid[w_set];
        end else if (r_state == ST_WRITE && w_stamp_wr) begin
            m_valid[r_set][w_fill_way] <= 1'b1;
            m_stamp[w_wr_addr]          <= r_stamp_ctr;
            if (!r_found) begin
                m_tag[w_wr_addr] <= r_tag;
            end
        end
        if (r_state == ST_READ) begin
            r_rd_tag   <= m_tag[w_rd_addr];
            r_rd_stamp <= m_stamp[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_stamp_ctr <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_reads     <= '0;
            r_writes    <= '0;
            o_valid     <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + CW'(1);
                    if (32'(r_clr) == SETS - 1) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (start) begin
                        r_addr     <= i_address;
                        r_pf_phase <= 1'b0;
                        r_hit      <= 1'b0;
                        r_pf       <= 1'b0;
                        if (i_opcode == OP_WRITE) r_writes <= r_writes + 32'd1;
                        r_state    <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    r_set   <= w_set;
                    r_tag   <= w_tagv;
                    r_way   <= '0;
                    r_found <= 1'b0;
                    r_inv   <= 1'b0;
                    r_vic_way <= '0;
                    r_state <= ST_READ;
                end
                ST_READ: begin
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    // one way per pass: tag compare, first-invalid and lowest-stamp
                    if (w_cur_valid && r_rd_tag == r_tag) begin
                        r_found   <= 1'b1;
                        r_hit_way <= w_cur;
                    end else if (!r_inv) begin
                        if (!w_cur_valid) begin
                            r_inv     <= 1'b1;
                            r_vic_way <= w_cur;
                        end else if (r_way == '0 || r_rd_stamp <= r_vic_stamp) begin
                            r_vic_way   <= w_cur;
                            r_vic_stamp <= r_rd_stamp;
                        end
                    end
                    if ((w_cur_valid && r_rd_tag == r_tag) || r_way + WCW'(1) == w_nways) begin
                        r_state <= ST_WRITE;
                    end else begin
                        r_way   <= r_way + WCW'(1);
                        r_state <= ST_READ;
                    end
                end
                ST_WRITE: begin
                    if (w_stamp_wr) r_stamp_ctr <= r_stamp_ctr + STAMP_BITS'(1);
                    if (!r_pf_phase) begin
                        if (r_found) begin
                            r_hit   <= 1'b1;
                            r_hits  <= r_hits + 32'd1;
                            r_state <= ST_DONE;
                        end else begin
                            r_misses <= r_misses + 32'd1;
                            r_reads  <= r_reads + 32'd1;
                            if (r_prefetch) begin
                                r_pf_phase <= 1'b1;
                                r_addr  <= r_addr + (ADDR_BITS'(1) << r_offset_bits);
                                r_state <= ST_ADDR;
                            end else begin
                                r_state <= ST_DONE;
                            end
                        end
                    end else begin
                        if (!r_found) begin
                            r_reads <= r_reads + 32'd1;
                            r_pf    <= 1'b1;
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    o_valid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_hit             = r_hit;
    assign o_prefetch_filled = r_pf;
    assign o_hits_total      = r_hits;
    assign o_misses_total    = r_misses;
    assign o_reads_total     = r_reads;
    assign o_writes_total    = r_writes;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_no_pf_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_prefetch_filled)) else $error("prefetch on hit");
    a_way_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_way < w_nways) else $error("way past limit");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("item not taken");
endmodule

FILE: test/tb_top.sv
// Testbench for the set-associative cache lookup block: directed table, extremes, then random accesses.
module tb_top;
    import sacl_pkg::*;

    localparam int SETS = 256;
    localparam int WAYS = 8;
    localparam int RAND_ITEMS = 1030;
    localparam longint CYCLE_LIMIT = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_opcode = 1'b0;
    logic [47:0] i_address = '0;
    logic        o_valid, o_hit, o_prefetch_filled;
    logic [31:0] o_hits_total, o_misses_total, o_reads_total, o_writes_total;

    set_assoc_cache_lookup_prefetch DUT (.*);

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic        hit;
        logic        pf;
        logic [31:0] hits, misses, reads, writes;
    } t_access_res;

    typedef struct {
        logic        op;
        logic [47:0] addr;
        logic        fixed;
        t_access_res res;
    } t_access_row;

    // predictor state
    logic        tag_valid [SETS*WAYS];
    logic [47:0] tag_store [SETS*WAYS];
    logic [31:0] stamp_store [SETS*WAYS];
    logic [31:0] stamp_ctr, n_hits, n_misses, n_reads, n_writes;
    logic [3:0]  c_index, c_offset, c_ways;
    logic        c_lru, c_pf;

    t_access_res pending_res [$];
    int  fails = 0;
    longint cycles = 0;

    function automatic int ways_live();
        if (c_ways == 0) return 1;
        if (c_ways > WAYS) return WAYS;
        return c_ways;
    endfunction

    function automatic int set_sel(logic [47:0] a);
        logic [47:0] s;
        s = (a >> c_offset) & ((48'd1 << c_index) - 48'd1);
        return int'(s % SETS);
    endfunction

    function automatic logic [47:0] tag_sel(logic [47:0] a);
        return a >> (5'(c_offset) + 5'(c_index));
    endfunction

    function automatic int way_lookup(int s, logic [47:0] t);
        for (int w = 0; w < ways_live(); w++)
            if (tag_valid[s*WAYS+w] && tag_store[s*WAYS+w] == t) return w;
        return -1;
    endfunction

    function automatic void install(int s, logic [47:0] t);
        int v;
        v = s * WAYS;
        for (int w = 0; w < ways_live(); w++) begin
            if (!tag_valid[s*WAYS+w]) begin
                v = s * WAYS + w;
                break;
            end
            if (stamp_store[s*WAYS+w] <= stamp_store[v]) v = s * WAYS + w;
        end
        tag_valid[v] = 1'b1;
        tag_store[v] = t;
        stamp_store[v] = stamp_ctr;
        stamp_ctr++;
    endfunction

    function automatic t_access_res cache_access(logic op, logic [47:0] a);
        t_access_res r;
        int s, w;
        logic [47:0] nxt;
        r = '0;
        if (op == OP_WRITE) n_writes++;
        s = set_sel(a);
        w = way_lookup(s, tag_sel(a));
        if (w >= 0) begin
            r.hit = 1'b1;
            n_hits++;
            if (c_lru == POLICY_LRU) begin
                stamp_store[s*WAYS+w] = stamp_ctr;
                stamp_ctr++;
            end
        end else begin
            n_misses++;
            n_reads++;
            install(s, tag_sel(a));
            if (c_pf) begin
                nxt = a + (48'd1 << c_offset);
                if (way_lookup(set_sel(nxt), tag_sel(nxt)) < 0) begin
                    n_reads++;
                    install(set_sel(nxt), tag_sel(nxt));
                    r.pf = 1'b1;
                end
            end
        end
        r.hits = n_hits;
        r.misses = n_misses;
        r.reads = n_reads;
        r.writes = n_writes;
        return r;
    endfunction

    task automatic random_gap();
        int g;
        g = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        repeat (g) @(posedge i_clk);
    endtask

    task automatic issue(logic op, logic [47:0] a);
        i_opcode <= op;
        i_address <= a;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_access(logic op, logic [47:0] a);
        pending_res.push_back(cache_access(op, a));
        issue(op, a);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [3:0] v);
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_INDEX_BITS:  c_index = v;
            REG_OFFSET_BITS: c_offset = v;
            REG_WAYS_USED:   c_ways = v;
            REG_POLICY:      c_lru = v[0];
            default:         c_pf = v[0];
        endcase
    endtask

    task automatic set_config(logic [3:0] ib, logic [3:0] ob, logic [3:0] wu, logic lr,
                              logic pf);
        write_reg(REG_INDEX_BITS, ib);
        write_reg(REG_OFFSET_BITS, ob);
        write_reg(REG_WAYS_USED, wu);
        write_reg(REG_POLICY, {3'b0, lr});
        write_reg(REG_PREFETCH, {3'b0, pf});
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_access_res got, want;
        if (i_rst_n && o_valid) begin
            got = {o_hit, o_prefetch_filled, o_hits_total, o_misses_total,
                   o_reads_total, o_writes_total};
            if (pending_res.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_res.pop_front();
                if (got !== want) begin
                    fails++;
                    if (fails <= 10) $display("mismatch exp %h got %h", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    t_access_row dir_rows [$];

    function automatic t_access_row mk(logic op, logic [47:0] a, logic fx = 0,
                                       t_access_res r = '0);
        t_access_row x;
        x.op = op; x.addr = a; x.fixed = fx; x.res = r;
        return x;
    endfunction

    initial begin
        logic [47:0] a, hot [16];
        t_access_res r;
        for (int i = 0; i < SETS*WAYS; i++) begin
            tag_valid[i] = 0; tag_store[i] = 0; stamp_store[i] = 0;
        end
        {stamp_ctr, n_hits, n_misses, n_reads, n_writes} = '0;
        c_index = 0; c_offset = 6; c_ways = 1; c_lru = 0; c_pf = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default config: one line, 64-byte blocks
        dir_rows.push_back(mk(0, 48'h0, 1, '{0, 0, 0, 1, 1, 0}));
        dir_rows.push_back(mk(1, 48'h3F, 1, '{1, 0, 1, 1, 1, 1}));
        dir_rows.push_back(mk(0, 48'hFFFF_FFFF_FFFF, 1, '{0, 0, 1, 2, 2, 1}));
        dir_rows.push_back(mk(1, 48'hFFFF_FFFF_FFC0, 1, '{1, 0, 2, 2, 2, 2}));
        dir_rows.push_back(mk(0, 48'h40));
        dir_rows.push_back(mk(0, 48'h0));
        foreach (dir_rows[i]) begin
            random_gap();
            r = cache_access(dir_rows[i].op, dir_rows[i].addr);
            pending_res.push_back(dir_rows[i].fixed ? dir_rows[i].res : r);
            issue(dir_rows[i].op, dir_rows[i].addr);
        end

        // extremes: widest index, zero/too many ways, wrap of next block
        set_config(8, 12, 0, 1, 1);
        send_access(0, 48'hFFFF_FFFF_FFFF);
        send_access(1, 48'h0);
        send_access(0, 48'h0);
        set_config(15, 0, 15, 0, 1);
        send_access(1, 48'hAAAA_5555_AAAA);
        send_access(0, 48'h5555_AAAA_5555);
        send_access(0, 48'hAAAA_5555_AAAB);
        send_access(0, 48'hFFFF_FFFF_FFFF);
        set_config(0, 15, 8, 1, 0);
        send_access(1, 48'h8000_0000_0000);
        send_access(0, 48'h7FFF_FFFF_FFFF);

        // random phases, mostly small address footprints to force conflicts
        for (int ph = 0; ph < 8; ph++) begin
            set_config(4'($urandom_range(0, 8)), 4'($urandom_range(0, 12)),
                       4'($urandom_range(0, 9)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
            foreach (hot[k]) hot[k] = 48'({$urandom, $urandom});
            for (int n = 0; n < RAND_ITEMS / 8; n++) begin
                if ($urandom_range(0, 9) < 8)
                    a = hot[$urandom_range(0, 15)] ^ 48'($urandom_range(0, 4095));
                else
                    a = 48'({$urandom, $urandom});
                if ($urandom_range(0, 9) == 0) random_gap();
                else if ($urandom_range(0, 1)) random_gap();
                send_access(1'($urandom_range(0, 1)), a);
            end
        end

        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

FILE: sim.f
sv/sacl_pkg.sv
sv/set_assoc_cache_lookup_prefetch.sv
test/tb_top.sv
